// File: rtl/core/triple_quadrature_knob_decoder_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the triple quadrature knob decoder
// Shorthand for concurrent assertions clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef TRIPLE_QUADRATURE_KNOB_DECODER_CORE_ASSERT_SVH
`define TRIPLE_QUADRATURE_KNOB_DECODER_CORE_ASSERT_SVH

// Assertion that is switched off while the active-low reset is asserted.
`define TQKD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that is also checked during reset.
`define TQKD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/core/tqkd_pkg.sv
// ----------------------------------------------------------------------------
// Knob decoder package
// Shared widths, reset values, the per-knob state type and the direction table.
// ----------------------------------------------------------------------------
package tqkd_pkg;

  localparam int unsigned PinW        = 6;
  localparam int unsigned LevelW      = 8;
  localparam int unsigned NumKnobsDef = 3;
  localparam int unsigned NumOutKnobs = 3;

  localparam logic [1:0]        AbReset     = 2'b11;
  localparam logic [LevelW-1:0] LevelReset  = 8'd128;
  localparam logic [LevelW-1:0] LevelMax    = 8'd255;
  localparam logic [LevelW-1:0] LevelMin    = 8'd0;
  localparam logic [LevelW-1:0] TopLimit    = 8'd250;
  localparam logic [LevelW-1:0] BottomLimit = 8'd5;
  localparam logic [LevelW-1:0] StepSize    = 8'd4;

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_UP,
    DIR_DOWN
  } dir_e;

  typedef struct packed {
    logic [1:0]        ab;
    logic [LevelW-1:0] level;
  } knob_state_t;

  // Index is the old A/B state in the upper two bits and the new one below.
  function automatic dir_e dir_lookup(logic [3:0] idx);
    dir_e dir;
    case (idx) inside
      4'h2, 4'h4, 4'hb, 4'hd: dir = DIR_UP;
      4'h1, 4'h7, 4'h8, 4'he: dir = DIR_DOWN;
      default:                dir = DIR_HOLD;
    endcase
    return dir;
  endfunction

endpackage

// File: rtl/core/tqkd_knob_lane.sv
// ----------------------------------------------------------------------------
// Knob update lane
// Decodes one knob's A/B transition and moves its level with saturation.
// ----------------------------------------------------------------------------
module tqkd_knob_lane (
  input  logic [1:0]           pair_i,
  input  logic [1:0]           last_pair_i,
  input  tqkd_pkg::knob_state_t state_i,
  output tqkd_pkg::knob_state_t state_o
);
  import tqkd_pkg::*;

  dir_e              dir;
  logic [LevelW-1:0] level_moved;

  assign dir = dir_lookup({state_i.ab, pair_i});

  always_comb begin
    case (dir)
      DIR_UP: begin
        level_moved = (state_i.level > TopLimit) ? LevelMax : state_i.level + StepSize;
      end
      DIR_DOWN: begin
        level_moved = (state_i.level < BottomLimit) ? LevelMin : state_i.level - StepSize;
      end
      default: begin
        level_moved = state_i.level;
      end
    endcase
  end

  // A knob whose pins are unchanged keeps its whole state.
  always_comb begin
    if (pair_i != last_pair_i) begin
      state_o.ab    = pair_i;
      state_o.level = level_moved;
    end else begin
      state_o = state_i;
    end
  end

endmodule

// File: rtl/core/triple_quadrature_knob_decoder_core.sv
// ----------------------------------------------------------------------------
// Triple quadrature knob decoder core
// Turns pin samples of up to three rotary encoders into saturating levels.
// ----------------------------------------------------------------------------
// Each input transaction carries one sample of six encoder pins, two per knob
// with A in the lower bit. Every transaction returns exactly one result
// transaction with the three 8-bit knob levels after that sample has been
// applied. It takes one transaction per clock unless a result stalls with the
// input register full. The sample lands in an input register; the per-knob
// lanes then decode it against the stored state and load the result register.
// The input register doubles as a skid stage: when it is empty, a new sample
// is still taken while a finished result waits for the consumer. Levels reset to
// 128, move by four per valid detent transition, and clamp at 0 and 255.
// When NUM_KNOBS is below three, the levels of the missing knobs read as 0.
module triple_quadrature_knob_decoder_core #(
  parameter int unsigned NUM_KNOBS = tqkd_pkg::NumKnobsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [tqkd_pkg::PinW-1:0]   pin_sample_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [tqkd_pkg::LevelW-1:0] knob_one_level_o,
  output logic [tqkd_pkg::LevelW-1:0] knob_two_level_o,
  output logic [tqkd_pkg::LevelW-1:0] knob_three_level_o
);
  import tqkd_pkg::*;

  localparam int unsigned PinsW = 2 * NUM_KNOBS;

  // Input stage: the sample waiting to be applied.
  logic            in_valid_q;
  logic [PinW-1:0] pin_q;

  // Decoder state.
  logic [PinsW-1:0] last_pins_q;
  knob_state_t      knob_q [NUM_KNOBS];
  knob_state_t      knob_d [NUM_KNOBS];

  // Result stage.
  logic              out_valid_q;
  logic [LevelW-1:0] out_level_q [NumOutKnobs];

  logic             advance;
  logic             in_accept;
  logic [PinsW-1:0] pins_ext;

  // The input stage moves on whenever the result register is free or drained.
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;

  // Pins above the configured knobs are dropped; missing pins read as low.
  if (PinsW <= PinW) begin : g_pins_cut
    assign pins_ext = pin_q[PinsW-1:0];
  end else begin : g_pins_pad
    assign pins_ext = {{(PinsW - PinW){1'b0}}, pin_q};
  end

  for (genvar k = 0; k < NUM_KNOBS; k++) begin : g_lane
    tqkd_knob_lane u_lane (
      .pair_i      (pins_ext[2*k +: 2]),
      .last_pair_i (last_pins_q[2*k +: 2]),
      .state_i     (knob_q[k]),
      .state_o     (knob_d[k])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pin_q <= pin_sample_i;
    end
  end

  // The stored state only moves when a sample is applied.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_pins_q <= '0;
      for (int k = 0; k < NUM_KNOBS; k++) begin
        knob_q[k].ab    <= AbReset;
        knob_q[k].level <= LevelReset;
      end
    end else if (advance) begin
      last_pins_q <= pins_ext;
      for (int k = 0; k < NUM_KNOBS; k++) begin
        knob_q[k] <= knob_d[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // The result register holds the levels after the applied sample; knobs
  // that are not configured stay at zero.
  for (genvar k = 0; k < NumOutKnobs; k++) begin : g_out
    if (k < NUM_KNOBS) begin : g_used
      always_ff @(posedge clk_i) begin
        if (advance) begin
          out_level_q[k] <= knob_d[k].level;
        end
      end
    end else begin : g_unused
      assign out_level_q[k] = '0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign knob_one_level_o   = out_level_q[0];
  assign knob_two_level_o   = out_level_q[1];
  assign knob_three_level_o = out_level_q[2];

endmodule

// File: rtl/core/tqkd_checker.sv
// ----------------------------------------------------------------------------
// Knob decoder checker
// Port-level assertions on the decoder core, attached by a bind statement.
// ----------------------------------------------------------------------------
`include "triple_quadrature_knob_decoder_core_assert.svh"

module tqkd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic [tqkd_pkg::PinW-1:0]   pin_sample_i,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic [tqkd_pkg::LevelW-1:0] knob_one_level_o,
  input logic [tqkd_pkg::LevelW-1:0] knob_two_level_o,
  input logic [tqkd_pkg::LevelW-1:0] knob_three_level_o
);
  import tqkd_pkg::*;

  logic              seen_q;
  logic [LevelW-1:0] last_one_q;
  logic [LevelW-1:0] delta;

  // Each result follows from one sample, so a level moves by at most one step.
  assign delta = (knob_one_level_o >= last_one_q) ? knob_one_level_o - last_one_q
                                                  : last_one_q - knob_one_level_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= 1'b0;
      last_one_q <= LevelReset;
    end else if (out_valid_o && out_ready_i) begin
      seen_q     <= 1'b1;
      last_one_q <= knob_one_level_o;
    end
  end

  `TQKD_ASSERT_ALWAYS(a_no_result_in_reset, clk_i, !rst_ni |-> !out_valid_o,
    "result transaction offered during reset")

  `TQKD_ASSERT(a_ready_when_drained, clk_i, rst_ni, (out_ready_i || !out_valid_o) |-> in_ready_o,
    "input stalled although the result side can drain")

  `TQKD_ASSERT(a_step_bounded, clk_i, rst_ni, (out_valid_o && seen_q) |-> (delta <= StepSize),
    "knob one level moved by more than one step between results")

  `TQKD_ASSERT(a_result_held, clk_i, rst_ni,
    (out_valid_o && !out_ready_i) |=>
      (out_valid_o && $stable(knob_one_level_o) && $stable(knob_two_level_o) &&
       $stable(knob_three_level_o)),
    "stalled result transaction changed")

  `TQKD_ASSERT(a_input_held, clk_i, rst_ni,
    (in_valid_i && !in_ready_o) |=> (in_valid_i && $stable(pin_sample_i)),
    "stalled input transaction changed")

endmodule

bind triple_quadrature_knob_decoder_core tqkd_checker u_tqkd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .pin_sample_i       (pin_sample_i),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .knob_one_level_o   (knob_one_level_o),
  .knob_two_level_o   (knob_two_level_o),
  .knob_three_level_o (knob_three_level_o)
);
